// ===== rtl/iadm_pkg.sv =====
// iadm_pkg: constants, codes and controller/datapath link types for the
// input action deadzone mapper; no dependencies
`default_nettype none
package iadm_pkg;
    localparam int NUM_INPUTS  = 64;
    localparam int NUM_ACTIONS = 4;
    localparam int FRAC_BITS   = 12;
    localparam int LVL_W  = FRAC_BITS + 1;
    localparam int IDX_W  = $clog2(NUM_INPUTS);
    localparam int ACT_W  = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
    localparam int CNT_W  = IDX_W + 1;
    localparam int DIV_STEPS = LVL_W;
    localparam int PEND_W = NUM_ACTIONS + 2;
    localparam logic [LVL_W-1:0] ONE_Q = LVL_W'(1) << FRAC_BITS;

    // operation codes
    localparam logic [1:0] OP_SET      = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_RD_INPUT = 2'd2;
    localparam logic [1:0] OP_RD_ACT   = 2'd3;

    // result kinds
    localparam logic [2:0] K_IN_PRESS   = 3'd0;
    localparam logic [2:0] K_IN_RELEASE = 3'd1;
    localparam logic [2:0] K_ACT_PRESS  = 3'd2;
    localparam logic [2:0] K_ACT_REL    = 3'd3;
    localparam logic [2:0] K_READ       = 3'd4;

    // register indexes
    localparam logic [2:0] REG_MASK0 = 3'd0;
    localparam logic [2:0] REG_DZ0   = 3'd4;

    typedef struct packed {
        logic             accept;
        logic             walk_rd;
        logic [IDX_W-1:0] walk_addr;
        logic             div_load;
        logic             div_step;
        logic             div_commit;
        logic [ACT_W-1:0] act_sel;
        logic             emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0]             new_op;
        logic [NUM_ACTIONS-1:0] bound;
        logic                   pend_empty;
    } status_t;
endpackage
`default_nettype wire

// ===== rtl/iadm_datapath.sv =====
// iadm_datapath: input level memory, edge flags, action max walk, deadzone
// divider and output register; depends on iadm_pkg
`default_nettype none
module iadm_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire iadm_pkg::cmd_t      cmd,
    output iadm_pkg::status_t        status,
    input  wire logic [23:0]         s_tdata,
    input  wire logic                cfg_valid,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [63:0]         cfg_data,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [23:0]              m_tdata,
    output logic [2:0]               m_tuser,
    output logic                     m_tlast
);
    import iadm_pkg::*;

    // configuration
    logic [NUM_INPUTS-1:0]  mask_reg [NUM_ACTIONS];
    logic [FRAC_BITS-1:0]   dz_reg   [NUM_ACTIONS];

    // input state: values in memory, zero-ness in flops
    logic [LVL_W-1:0]      mem [NUM_INPUTS];
    logic [LVL_W-1:0]      rdata_reg;
    logic [NUM_INPUTS-1:0] lvl_nz_reg, prior_nz_reg;

    // action state
    logic [LVL_W-1:0]       act_lvl_reg  [NUM_ACTIONS];
    logic [NUM_ACTIONS-1:0] act_prior_nz_reg;
    logic [LVL_W-1:0]       mx_reg [NUM_ACTIONS];
    logic [NUM_ACTIONS-1:0] act_rel_reg;

    // item latch
    logic [1:0]       op_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [LVL_W-1:0] in_lvl_reg;
    logic             in_rel_reg;
    logic [PEND_W-1:0] pend_reg;

    // walk pipeline
    logic             wv_reg;
    logic [IDX_W-1:0] waddr_reg;

    // divider
    logic [LVL_W-1:0] rem_reg, nsh_reg, q_reg, dvs_reg;

    logic [1:0]       s_op;
    logic [IDX_W-1:0] s_idx;
    logic [LVL_W-1:0] s_str, sat;
    logic [IDX_W-1:0] rd_addr;
    logic [LVL_W:0]   trial;
    logic [LVL_W-1:0] mx_sel, diff;
    logic [FRAC_BITS-1:0] dz_sel;
    logic [PEND_W-1:0] pick;
    logic [2:0]        o_kind;
    logic [IDX_W-1:0]  o_which;
    logic [LVL_W-1:0]  o_lvl;
    logic              o_jp, o_jr;
    logic              out_free;
    logic              rd_nz, rd_pnz;

    assign s_op  = s_tdata[1:0];
    assign s_idx = s_tdata[7:2];
    assign s_str = s_tdata[20:8];
    assign sat   = (s_str > ONE_Q) ? ONE_Q : s_str;

    // status back to the controller
    always_comb begin
        status.new_op     = s_op;
        status.pend_empty = (pend_reg == '0);
        for (int a = 0; a < NUM_ACTIONS; a++) begin
            status.bound[a] = mask_reg[a][idx_reg];
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < NUM_ACTIONS; a++) begin
                mask_reg[a] <= '0;
                dz_reg[a]   <= '0;
            end
        end else if (cfg_valid) begin
            for (int a = 0; a < NUM_ACTIONS; a++) begin
                if (cfg_index == REG_MASK0 + 3'(a)) begin
                    mask_reg[a] <= cfg_data[NUM_INPUTS-1:0];
                end
                if (cfg_index == REG_DZ0 + 3'(a)) begin
                    dz_reg[a] <= cfg_data[FRAC_BITS-1:0];
                end
            end
        end
    end

    // level memory: write on set, read for walk or input read
    // after accept the read address stays on the latched index
    assign rd_addr = cmd.walk_rd ? cmd.walk_addr : (cmd.accept ? s_idx : idx_reg);
    always_ff @(posedge aclk) begin
        if (cmd.accept && s_op == OP_SET) begin
            mem[s_idx] <= sat;
        end
        rdata_reg <= mem[rd_addr];
    end

    // zero flags and action state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_nz_reg       <= '0;
            prior_nz_reg     <= '0;
            act_prior_nz_reg <= '0;
            for (int a = 0; a < NUM_ACTIONS; a++) begin
                act_lvl_reg[a] <= '0;
            end
        end else begin
            if (cmd.accept && s_op == OP_SET) begin
                prior_nz_reg[s_idx] <= lvl_nz_reg[s_idx];
                lvl_nz_reg[s_idx]   <= (sat != '0);
            end
            if (cmd.accept && s_op == OP_TICK) begin
                prior_nz_reg <= lvl_nz_reg;
                for (int a = 0; a < NUM_ACTIONS; a++) begin
                    act_prior_nz_reg[a] <= (act_lvl_reg[a] != '0);
                end
            end
            if (cmd.div_commit) begin
                act_prior_nz_reg[cmd.act_sel] <= (act_lvl_reg[cmd.act_sel] != '0);
                act_lvl_reg[cmd.act_sel]      <= q_reg;
            end
        end
    end

    // item latch and pending result mask
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else if (cmd.accept) begin
            if (s_op == OP_SET) begin
                pend_reg <= {{(PEND_W-1){1'b0}}, ((sat != '0) != lvl_nz_reg[s_idx])};
            end else if (s_op != OP_TICK) begin
                pend_reg <= {1'b1, {(PEND_W-1){1'b0}}};
            end else begin
                pend_reg <= '0;
            end
        end else if (cmd.div_commit) begin
            pend_reg[1 + cmd.act_sel] <=
                (q_reg != '0) != (act_lvl_reg[cmd.act_sel] != '0);
        end else if (cmd.emit && out_free) begin
            pend_reg <= pend_reg & ~pick;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg     <= s_op;
            idx_reg    <= s_idx;
            in_lvl_reg <= sat;
            in_rel_reg <= (sat == '0);
        end
        if (cmd.div_commit) begin
            act_rel_reg[cmd.act_sel] <= (q_reg == '0);
        end
    end

    // max walk over bound inputs, all actions at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wv_reg <= 1'b0;
        end else begin
            wv_reg <= cmd.walk_rd;
        end
        waddr_reg <= cmd.walk_addr;
        for (int a = 0; a < NUM_ACTIONS; a++) begin
            if (cmd.accept) begin
                mx_reg[a] <= '0;
            end else if (wv_reg && mask_reg[a][waddr_reg] && lvl_nz_reg[waddr_reg]
                         && rdata_reg > mx_reg[a]) begin
                mx_reg[a] <= rdata_reg;
            end
        end
    end

    // restoring divider: (s - dz) * ONE / (ONE - dz)
    assign mx_sel = mx_reg[cmd.act_sel];
    assign dz_sel = dz_reg[cmd.act_sel];
    assign diff   = (mx_sel > LVL_W'(dz_sel)) ? mx_sel - LVL_W'(dz_sel) : '0;
    assign trial  = {rem_reg, nsh_reg[LVL_W-1]};

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            rem_reg <= diff >> 1;
            nsh_reg <= {diff[0], {(LVL_W-1){1'b0}}};
            q_reg   <= '0;
            dvs_reg <= ONE_Q - LVL_W'(dz_sel);
        end else if (cmd.div_step) begin
            nsh_reg <= nsh_reg << 1;
            if (trial >= {1'b0, dvs_reg}) begin
                rem_reg <= LVL_W'(trial - {1'b0, dvs_reg});
                q_reg   <= {q_reg[LVL_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[LVL_W-1:0];
                q_reg   <= {q_reg[LVL_W-2:0], 1'b0};
            end
        end
    end

    // pick lowest pending result
    assign pick = pend_reg & (~pend_reg + PEND_W'(1));

    always_comb begin
        rd_nz  = 1'b0;
        rd_pnz = 1'b0;
        o_kind  = K_READ;
        o_which = idx_reg;
        o_lvl   = '0;
        o_jp    = 1'b0;
        o_jr    = 1'b0;
        if (pick[0]) begin
            o_kind = in_rel_reg ? K_IN_RELEASE : K_IN_PRESS;
            o_lvl  = in_lvl_reg;
        end else if (pick[PEND_W-1]) begin
            if (op_reg == OP_RD_INPUT) begin
                rd_nz  = lvl_nz_reg[idx_reg];
                rd_pnz = prior_nz_reg[idx_reg];
                o_lvl  = rd_nz ? rdata_reg : '0;
            end else if (32'(idx_reg) < NUM_ACTIONS) begin
                o_lvl  = act_lvl_reg[ACT_W'(idx_reg)];
                rd_nz  = (o_lvl != '0);
                rd_pnz = act_prior_nz_reg[ACT_W'(idx_reg)];
            end
            o_jp = rd_nz && !rd_pnz;
            o_jr = !rd_nz && rd_pnz;
        end else begin
            for (int a = NUM_ACTIONS - 1; a >= 0; a--) begin
                if (pick[1 + a]) begin
                    o_kind  = act_rel_reg[a] ? K_ACT_REL : K_ACT_PRESS;
                    o_which = IDX_W'(a);
                    o_lvl   = act_lvl_reg[a];
                end
            end
        end
    end

    // output register
    assign out_free = !m_tvalid || m_tready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (cmd.emit && out_free && pend_reg != '0) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
        if (cmd.emit && out_free && pend_reg != '0) begin
            m_tdata <= {3'b0, o_jr, o_jp, o_lvl, o_which};
            m_tuser <= o_kind;
            m_tlast <= ((pend_reg & ~pick) == '0);
        end
    end

    // quotient never exceeds full strength
    a_q_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_commit |-> q_reg <= ONE_Q) else $error("quotient above one");
    // pending mask shrinks by at most one result per emitted transaction
    a_pend_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && !cmd.accept && !cmd.div_commit) |=>
            $countones($past(pend_reg)) - $countones(pend_reg) <= 1)
        else $error("more than one result dropped");
endmodule
`default_nettype wire

// ===== rtl/iadm_ctrl.sv =====
// iadm_ctrl: sequencer for set, tick and read items (walk, divide, emit);
// depends on iadm_pkg
`default_nettype none
module iadm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire iadm_pkg::status_t status,
    output iadm_pkg::cmd_t         cmd
);
    import iadm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_DIVL, S_DIVS, S_DIVC, S_EMIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [ACT_W-1:0] act_reg;
    logic             accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // command decode
    always_comb begin
        cmd            = '0;
        cmd.accept     = accept;
        cmd.walk_rd    = (state_reg == S_WALK) && (cnt_reg < CNT_W'(NUM_INPUTS));
        cmd.walk_addr  = cnt_reg[IDX_W-1:0];
        cmd.div_load   = (state_reg == S_DIVL) && status.bound[act_reg];
        cmd.div_step   = (state_reg == S_DIVS);
        cmd.div_commit = (state_reg == S_DIVC);
        cmd.act_sel    = act_reg;
        cmd.emit       = (state_reg == S_EMIT);
    end

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            act_reg   <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    cnt_reg <= '0;
                    act_reg <= '0;
                    if (accept) begin
                        priority if (status.new_op == OP_SET) begin
                            state_reg <= S_WALK;
                        end else if (status.new_op == OP_TICK) begin
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_WALK: begin
                    if (cnt_reg == CNT_W'(NUM_INPUTS)) begin
                        state_reg <= S_DIVL;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_DIVL: begin
                    cnt_reg <= '0;
                    if (status.bound[act_reg]) begin
                        state_reg <= S_DIVS;
                    end else if (act_reg == ACT_W'(NUM_ACTIONS - 1)) begin
                        state_reg <= S_EMIT;
                    end else begin
                        act_reg <= act_reg + ACT_W'(1);
                    end
                end
                S_DIVS: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                        state_reg <= S_DIVC;
                    end
                end
                S_DIVC: begin
                    if (act_reg == ACT_W'(NUM_ACTIONS - 1)) begin
                        state_reg <= S_EMIT;
                    end else begin
                        act_reg   <= act_reg + ACT_W'(1);
                        state_reg <= S_DIVL;
                    end
                end
                S_EMIT: begin
                    if (status.pend_empty) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_set_walks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && status.new_op == OP_SET) |=> state_reg == S_WALK)
        else $error("set did not start walk");
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIVS && cnt_reg == CNT_W'(DIV_STEPS - 1)) |=> state_reg == S_DIVC)
        else $error("divide length wrong");
    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && status.pend_empty) |=> state_reg == S_IDLE)
        else $error("emit did not finish");
endmodule
`default_nettype wire

// ===== rtl/input_action_deadzone_mapper.sv =====
// Set items walk the 64-entry level memory and divide for each bound action,
// then give one result per cycle while the output is not stalled; ticks give
// none; reads give one reply. One item at a time, a set held by the walk and the
// one-bit-per-cycle deadzone divider. Synchronous active-low reset clears input
// zero flags, action levels, edge flags, bindings and deadzones; no clearing pass.
// top level: joins controller and datapath; depends on iadm_pkg, iadm_ctrl,
// iadm_datapath
`default_nettype none
module input_action_deadzone_mapper (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // operation[1:0], index[7:2], strength[20:8]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // which[5:0], level[18:6], just_pressed[19],
                                        // just_released[20]
    output logic [2:0]       m_tuser,   // kind[2:0]
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import iadm_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    iadm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    iadm_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );
endmodule
`default_nettype wire

// ===== dv/input_action_deadzone_mapper_tb.sv =====
// testbench for input_action_deadzone_mapper: directed table then random
// set/tick/read traffic, checked against an in-bench predictor; uses iadm_pkg
`timescale 1ns / 1ps
module input_action_deadzone_mapper_tb;
    import iadm_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  which;
        logic [12:0] level;
        logic        jp;
        logic        jr;
        logic        last;
    } event_t;

    typedef struct {
        logic [1:0]  op;
        logic [5:0]  idx;
        logic [12:0] str;
        logic        has_exp;
        event_t      exp;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    input_action_deadzone_mapper dut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [63:0] pm_mask [4];
    logic [11:0] pm_dz [4];
    logic [12:0] pm_in_lvl [64];
    logic [12:0] pm_in_pri [64];
    logic [12:0] pm_act_lvl [4];
    logic [12:0] pm_act_pri [4];

    event_t expected_events [$];
    int     errors = 0;
    int     idle_cnt = 0;
    bit     hold_long = 0;

    function automatic logic [1:0] edge_kind(logic [12:0] lv, logic [12:0] pr);
        if (lv != 0) return (pr == 0) ? 2'd1 : 2'd0;
        return (pr != 0) ? 2'd2 : 2'd0;
    endfunction

    function automatic logic [12:0] deadzone_scale(logic [12:0] s, logic [11:0] dz);
        logic [31:0] q;
        if (s <= dz) return '0;
        q = ((32'(s) - dz) * 32'(ONE_Q)) / (32'(ONE_Q) - dz);
        return q[12:0];
    endfunction

    // compute the events one item causes and queue them
    task automatic predict_item(logic [1:0] op, logic [5:0] idx, logic [12:0] str_in);
        event_t      ev [$];
        event_t      e;
        logic [12:0] s, mx;
        logic [1:0]  ek;
        ev = {};
        if (op == OP_SET) begin
            s = (str_in > ONE_Q) ? ONE_Q : str_in;
            pm_in_pri[idx] = pm_in_lvl[idx];
            pm_in_lvl[idx] = s;
            ek = edge_kind(s, pm_in_pri[idx]);
            if (ek != 0) begin
                e = '{kind: (ek == 1) ? K_IN_PRESS : K_IN_RELEASE, which: idx,
                      level: s, jp: 0, jr: 0, last: 0};
                ev.push_back(e);
            end
            for (int a = 0; a < 4; a++) begin
                if (pm_mask[a][idx]) begin
                    mx = 0;
                    for (int i = 0; i < 64; i++)
                        if (pm_mask[a][i] && pm_in_lvl[i] > mx) mx = pm_in_lvl[i];
                    pm_act_pri[a] = pm_act_lvl[a];
                    pm_act_lvl[a] = deadzone_scale(mx, pm_dz[a]);
                    ek = edge_kind(pm_act_lvl[a], pm_act_pri[a]);
                    if (ek != 0) begin
                        e = '{kind: (ek == 1) ? K_ACT_PRESS : K_ACT_REL, which: 6'(a),
                              level: pm_act_lvl[a], jp: 0, jr: 0, last: 0};
                        ev.push_back(e);
                    end
                end
            end
        end else if (op == OP_TICK) begin
            for (int i = 0; i < 64; i++) pm_in_pri[i] = pm_in_lvl[i];
            for (int a = 0; a < 4; a++) pm_act_pri[a] = pm_act_lvl[a];
        end else begin
            e = '{kind: K_READ, which: idx, level: 0, jp: 0, jr: 0, last: 0};
            if (op == OP_RD_INPUT) begin
                e.level = pm_in_lvl[idx];
                ek = edge_kind(pm_in_lvl[idx], pm_in_pri[idx]);
            end else if (idx < 4) begin
                e.level = pm_act_lvl[idx];
                ek = edge_kind(pm_act_lvl[idx], pm_act_pri[idx]);
            end else begin
                ek = 0;
            end
            e.jp = (ek == 1);
            e.jr = (ek == 2);
            ev.push_back(e);
        end
        if (ev.size() > 0) ev[ev.size()-1].last = 1'b1;
        foreach (ev[k]) expected_events.push_back(ev[k]);
    endtask

    // valid stays up between back-to-back transactions; the caller drops it
    task automatic send_item(logic [1:0] op, logic [5:0] idx, logic [12:0] str);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        predict_item(op, idx, str);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, str, idx, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // valid stays up between writes; the caller drops it after the last one
    task automatic write_reg(logic [2:0] ri, logic [63:0] val);
        if (ri < REG_DZ0) pm_mask[ri] = val;
        else pm_dz[ri - REG_DZ0] = val[11:0];
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // wait for the queue to drain plus some slack for result-free items
    task automatic drain();
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // receiver: random stalls, one long hold-off
    always @(posedge aclk) begin
        if (hold_long) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 19) < 12);
    end

    // result checker
    always @(posedge aclk) begin
        event_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{kind: m_tuser, which: m_tdata[5:0], level: m_tdata[18:6],
                    jp: m_tdata[19], jr: m_tdata[20], last: m_tlast};
            if (expected_events.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none, actual %h", $time, got);
            end else begin
                want = expected_events.pop_front();
                if (got != want) begin
                    errors++;
                    $display("%0t mismatch: expected %h, actual %h", $time, want, got);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > 20000) begin
            $display("FAILURE");
            $finish;
        end
    end

    row_t table_rows [$];

    task automatic add_row(logic [1:0] op, logic [5:0] idx, logic [12:0] str,
                           logic he, event_t ex);
        row_t r;
        r.op = op; r.idx = idx; r.str = str; r.has_exp = he; r.exp = ex;
        table_rows.push_back(r);
    endtask

    task automatic random_phase(int n);
        logic [1:0] op;
        logic [5:0] idx;
        logic [12:0] str;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin op = OP_SET; end
                5: op = OP_TICK;
                6, 7: op = OP_RD_INPUT;
                default: op = OP_RD_ACT;
            endcase
            idx = (op == OP_RD_ACT && $urandom_range(0, 3) != 0) ?
                  6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63));
            if (op == OP_SET && $urandom_range(0, 2) == 0) idx = 6'($urandom_range(0, 7));
            case ($urandom_range(0, 5))
                0: str = 0;
                1: str = ONE_Q;
                2: str = 13'($urandom_range(4097, 8191));
                default: str = 13'($urandom_range(0, 4096));
            endcase
            send_item(op, idx, str);
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        event_t nx;
        for (int i = 0; i < 64; i++) begin pm_in_lvl[i] = 0; pm_in_pri[i] = 0; end
        for (int a = 0; a < 4; a++) begin
            pm_mask[a] = 0; pm_dz[a] = 0; pm_act_lvl[a] = 0; pm_act_pri[a] = 0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table: reset reads, extremes, saturation, out of range read
        nx = '0;
        add_row(OP_RD_INPUT, 63, 0, 1, '{K_READ, 6'd63, 13'd0, 1'b0, 1'b0, 1'b1});
        add_row(OP_RD_ACT, 3, 0, 1, '{K_READ, 6'd3, 13'd0, 1'b0, 1'b0, 1'b1});
        add_row(OP_RD_ACT, 63, 8191, 1, '{K_READ, 6'd63, 13'd0, 1'b0, 1'b0, 1'b1});
        add_row(OP_SET, 0, 8191, 1, '{K_IN_PRESS, 6'd0, ONE_Q, 1'b0, 1'b0, 1'b1});
        add_row(OP_RD_INPUT, 0, 0, 1, '{K_READ, 6'd0, ONE_Q, 1'b1, 1'b0, 1'b1});
        add_row(OP_SET, 0, 0, 1, '{K_IN_RELEASE, 6'd0, 13'd0, 1'b0, 1'b0, 1'b1});
        add_row(OP_SET, 0, 0, 0, nx);
        add_row(OP_TICK, 0, 0, 0, nx);
        add_row(OP_RD_INPUT, 0, 0, 1, '{K_READ, 6'd0, 13'd0, 1'b0, 1'b0, 1'b1});
        add_row(OP_SET, 63, ONE_Q, 1, '{K_IN_PRESS, 6'd63, ONE_Q, 1'b0, 1'b0, 1'b1});
        add_row(OP_SET, 63, 1, 0, nx);
        add_row(OP_RD_INPUT, 63, 0, 0, nx);
        foreach (table_rows[k]) begin
            if (table_rows[k].has_exp) begin
                send_item(table_rows[k].op, table_rows[k].idx, table_rows[k].str);
                void'(expected_events.pop_back());
                expected_events.push_back(table_rows[k].exp);
            end else begin
                send_item(table_rows[k].op, table_rows[k].idx, table_rows[k].str);
            end
        end
        s_tvalid <= 1'b0;
        drain();

        // bindings and deadzones in several settings, extremes among them
        write_reg(REG_MASK0 + 0, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_MASK0 + 1, 64'h0000_0000_0000_00FF);
        write_reg(REG_MASK0 + 2, 64'h8000_0000_0000_0001);
        write_reg(REG_MASK0 + 3, 64'h0);
        write_reg(REG_DZ0 + 0, 0);
        write_reg(REG_DZ0 + 1, 4095);
        write_reg(REG_DZ0 + 2, 2048);
        write_reg(REG_DZ0 + 3, 100);
        cfg_valid <= 1'b0;
        table_rows = {};
        add_row(OP_SET, 0, 4096, 0, nx);
        add_row(OP_SET, 63, 3000, 0, nx);
        add_row(OP_SET, 5, 4095, 0, nx);
        add_row(OP_RD_ACT, 0, 0, 0, nx);
        add_row(OP_RD_ACT, 1, 0, 0, nx);
        add_row(OP_RD_ACT, 2, 0, 0, nx);
        add_row(OP_SET, 0, 0, 0, nx);
        add_row(OP_SET, 63, 0, 0, nx);
        add_row(OP_TICK, 0, 0, 0, nx);
        add_row(OP_RD_ACT, 2, 0, 0, nx);
        foreach (table_rows[k])
            send_item(table_rows[k].op, table_rows[k].idx, table_rows[k].str);
        s_tvalid <= 1'b0;
        drain();

        // random phases under fresh register settings
        for (int ph = 0; ph < 4; ph++) begin
            for (int a = 0; a < 4; a++) begin
                write_reg(REG_MASK0 + 3'(a), (ph == 3) ? 64'hFF << (8 * a) : rand64());
                write_reg(REG_DZ0 + 3'(a), (ph == 0) ? 0 : (ph == 1) ? 4095 :
                          64'($urandom_range(0, 4095)));
            end
            cfg_valid <= 1'b0;
            if (ph == 2) begin
                fork
                    begin
                        hold_long = 1;
                        repeat (600) @(posedge aclk);
                        hold_long = 0;
                    end
                    random_phase(25);
                join
            end else begin
                random_phase(25);
            end
            drain();
        end

        if (errors == 0 && expected_events.size() == 0) begin
            $display("SUCCESS");
        end else begin
            if (expected_events.size() != 0)
                $display("%0t leftover: expected %0d more results, actual 0",
                         $time, expected_events.size());
            $display("FAILURE");
        end
        $finish;
    end
endmodule
